// ===== hw/rtl/polyline_corner_detector_macros.svh =====
// Assertion macros used by the checker of the polyline corner detector.
`ifndef POLYLINE_CORNER_DETECTOR_MACROS_SVH
`define POLYLINE_CORNER_DETECTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcd check failed: lbl");

// Consequent must hold in the cycle after the antecedent.
`define PCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcd check failed: lbl");

`endif

// ===== hw/rtl/pcd_pkg.sv =====
`default_nettype none

package pcd_pkg;

   localparam int COORD_BITS = 16;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DELTA_BITS;
   localparam int TERM_BITS  = PROD_BITS + 1;
   localparam int THR_BITS   = 10;
   localparam int SCALE_BITS = PROD_BITS + THR_BITS;

   localparam int AXIS_LIMIT = 200;
   localparam int LIMIT_BITS = $clog2(AXIS_LIMIT + 1);
   localparam logic [LIMIT_BITS-1:0] AXIS_LIMIT_V = LIMIT_BITS'(AXIS_LIMIT);
   localparam logic [THR_BITS-1:0]   THR_RESET    = THR_BITS'(50);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int HELD_BITS = 2;
   localparam logic [HELD_BITS-1:0] HELD_FULL = HELD_BITS'(2);

   // How the back end has to judge a window.
   localparam logic [1:0] KIND_SKIP  = 2'd0;
   localparam logic [1:0] KIND_AXIS  = 2'd1;
   localparam logic [1:0] KIND_SLOPE = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;

   typedef struct packed {
      logic [1:0] kind;
      coord_type  mid_x;
      coord_type  mid_y;
      delta_type  dx1;
      delta_type  dy1;
      delta_type  dx2;
      delta_type  dy2;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } slot_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pcd_channels.sv =====
`default_nettype none

interface pcd_point_if import pcd_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      starts_path;

   modport source (output valid, point_x, point_y, starts_path, input ready);
   modport sink (input valid, point_x, point_y, starts_path, output ready);
endinterface

interface pcd_corner_if import pcd_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type corner_x;
   coord_type corner_y;

   modport source (output valid, corner_x, corner_y, input ready);
   modport sink (input valid, corner_x, corner_y, output ready);
endinterface

interface pcd_csr_if import pcd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [THR_BITS-1:0] corner_threshold;

   modport source (output valid, corner_threshold, input ready);
   modport sink (input valid, corner_threshold, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcd_front.sv =====
`default_nettype none

module pcd_front import pcd_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   pcd_point_if.sink   req_chan,
   input  wire         queue_full,
   output slot_type    push
);

   logic [HELD_BITS-1:0] held_ff, held_in, held_eff;
   coord_type older_x_ff, older_y_ff, mid_x_ff, mid_y_ff;
   delta_type dx1, dy1, dx2, dy2;
   logic [1:0] kind;
   logic       accept;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;

   assign held_eff = req_chan.starts_path ? '0 : held_ff;

   assign dx1 = DELTA_BITS'(mid_x_ff) - DELTA_BITS'(older_x_ff);
   assign dy1 = DELTA_BITS'(mid_y_ff) - DELTA_BITS'(older_y_ff);
   assign dx2 = DELTA_BITS'(req_chan.point_x) - DELTA_BITS'(mid_x_ff);
   assign dy2 = DELTA_BITS'(req_chan.point_y) - DELTA_BITS'(mid_y_ff);

   // A zero-length first side counts as vertical.
   always_comb begin
      if (held_eff != HELD_FULL) begin
         kind = KIND_SKIP;
      end else if (dx1 == '0) begin
         kind = (dx2 != '0) ? KIND_AXIS : KIND_SKIP;
      end else if (dy1 == '0) begin
         kind = (dy2 != '0) ? KIND_AXIS : KIND_SKIP;
      end else if (dx2 == '0) begin
         kind = KIND_AXIS;
      end else begin
         kind = KIND_SLOPE;
      end
   end

   assign held_in = (held_eff == HELD_FULL) ? HELD_FULL : held_eff + 1'b1;

   always_comb begin
      push.valid      = accept && (kind != KIND_SKIP);
      push.work.kind  = kind;
      push.work.mid_x = mid_x_ff;
      push.work.mid_y = mid_y_ff;
      push.work.dx1   = dx1;
      push.work.dy1   = dy1;
      push.work.dx2   = dx2;
      push.work.dy2   = dy2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         older_x_ff <= '0;
         older_y_ff <= '0;
         mid_x_ff   <= '0;
         mid_y_ff   <= '0;
      end else if (accept) begin
         held_ff    <= held_in;
         older_x_ff <= mid_x_ff;
         older_y_ff <= mid_y_ff;
         mid_x_ff   <= req_chan.point_x;
         mid_y_ff   <= req_chan.point_y;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pcd_queue.sv =====
`default_nettype none

module pcd_queue import pcd_pkg::*; (
   input  wire            clock,
   input  wire            reset,
   input  wire slot_type  push,
   input  wire            pop,
   output logic           full,
   output slot_type       head
);

   work_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic do_push, do_pop;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.work  = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pcd_back.sv =====
`default_nettype none

module pcd_back import pcd_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [THR_BITS-1:0] threshold,
   input  wire  slot_type      head,
   output logic                pop,
   pcd_corner_if.source        rsp_chan
);

   logic advance;

   // Stage 1: cross products.
   logic      s1_valid_ff;
   logic [1:0] s1_kind_ff;
   coord_type s1_x_ff, s1_y_ff;
   logic signed [PROD_BITS-1:0] prod_a_ff, prod_b_ff;

   // Stage 2: magnitudes of difference and sum.
   logic      s2_valid_ff;
   logic [1:0] s2_kind_ff;
   coord_type s2_x_ff, s2_y_ff;
   logic [PROD_BITS-1:0] mag_diff_ff, mag_sum_ff, mag_diff_in, mag_sum_in;
   logic signed [TERM_BITS-1:0] term_diff, term_sum;

   // Stage 3: scaled magnitudes.
   logic      s3_valid_ff;
   logic [1:0] s3_kind_ff;
   coord_type s3_x_ff, s3_y_ff;
   logic [SCALE_BITS-1:0] scaled_diff_ff, scaled_sum_ff;

   // Output register.
   logic      rsp_valid_ff, rsp_valid_in, is_corner;
   coord_type corner_x_ff, corner_y_ff;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign pop     = advance && head.valid;

   assign term_diff   = TERM_BITS'(prod_a_ff) - TERM_BITS'(prod_b_ff);
   assign term_sum    = TERM_BITS'(prod_a_ff) + TERM_BITS'(prod_b_ff);
   assign mag_diff_in = term_diff[TERM_BITS-1] ? PROD_BITS'(-term_diff)
                                                : PROD_BITS'(term_diff);
   assign mag_sum_in  = term_sum[TERM_BITS-1] ? PROD_BITS'(-term_sum)
                                               : PROD_BITS'(term_sum);

   always_comb begin
      if (s3_kind_ff == KIND_AXIS) begin
         is_corner = (threshold < THR_BITS'(AXIS_LIMIT));
      end else begin
         is_corner = (scaled_diff_ff > scaled_sum_ff);
      end
   end

   assign rsp_valid_in = s3_valid_ff && is_corner;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff     <= head.work.kind;
         s1_x_ff        <= head.work.mid_x;
         s1_y_ff        <= head.work.mid_y;
         prod_a_ff      <= head.work.dy2 * head.work.dx1;
         prod_b_ff      <= head.work.dy1 * head.work.dx2;
         s2_kind_ff     <= s1_kind_ff;
         s2_x_ff        <= s1_x_ff;
         s2_y_ff        <= s1_y_ff;
         mag_diff_ff    <= mag_diff_in;
         mag_sum_ff     <= mag_sum_in;
         s3_kind_ff     <= s2_kind_ff;
         s3_x_ff        <= s2_x_ff;
         s3_y_ff        <= s2_y_ff;
         scaled_diff_ff <= SCALE_BITS'(mag_diff_ff) * SCALE_BITS'(AXIS_LIMIT_V);
         scaled_sum_ff  <= SCALE_BITS'(mag_sum_ff) * SCALE_BITS'(threshold);
         corner_x_ff    <= s3_x_ff;
         corner_y_ff    <= s3_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= head.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.corner_x = corner_x_ff;
   assign rsp_chan.corner_y = corner_y_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/polyline_corner_detector.sv =====
// Polyline corner detector.
// Points arrive as beats on req_chan (point_x, point_y, starts_path). The block
// keeps the two previous points of the current path; each new point closes a
// window and the middle point is judged. A corner leaves as one beat on
// rsp_chan carrying the middle point; a non-corner leaves no beat at all.
// A beat with starts_path set begins a new path, so its first two points only
// fill the window. csr_chan writes corner_threshold (reset value 50); it is
// always ready and must only be written while no point is in flight.
// Throughput is one point per cycle while req_chan.ready is high. A corner's
// closing point passes through the front-to-back queue, then the product,
// magnitude and scaling stages and the output register before the corner
// appears on rsp_chan. The two-entry queue lets the front keep taking points
// while the back is held. When the receiver stalls, the whole back pipeline
// freezes behind the output register, the queue fills, and req_chan.ready
// drops once two judged windows wait. Synchronous reset empties the window,
// queue and pipeline and restores the threshold.
`default_nettype none

module polyline_corner_detector import pcd_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   pcd_point_if.sink     req_chan,
   pcd_corner_if.source  rsp_chan,
   pcd_csr_if.sink       csr_chan
);

   logic [THR_BITS-1:0] threshold_ff;
   slot_type push, head;
   logic     queue_full, pop;

   // The threshold register takes every write at once.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_chan.valid) begin
         threshold_ff <= csr_chan.corner_threshold;
      end
   end

   // Front end: window and classification of each closed window.
   pcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   // Windows that need a verdict wait here.
   pcd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // Back end: slope comparison or axis test, and result register.
   pcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .head      (head),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/pcd_checker.sv =====
`default_nettype none
`include "polyline_corner_detector_macros.svh"

module pcd_checker import pcd_pkg::*; (
   input wire            clock,
   input wire            reset,
   input wire            req_valid,
   input wire            req_ready,
   input wire            rsp_valid,
   input wire            rsp_ready,
   input wire coord_type corner_x,
   input wire coord_type corner_y
);

   logic [1:0] seen_ff;

   // Counts accepted points since reset, saturating at three.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (req_valid && req_ready && seen_ff != 2'd3) begin
         seen_ff <= seen_ff + 1'b1;
      end
   end

   `PCD_ASSERT_NEXT(rsp_hold_valid, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PCD_ASSERT_NEXT(rsp_hold_data, clock, reset, rsp_valid && !rsp_ready, $stable(corner_x) && $stable(corner_y))
   `PCD_ASSERT_NEXT(rsp_clear_on_reset, clock, 1'b0, reset, !rsp_valid)
   `PCD_ASSERT_SAME(rsp_needs_window, clock, reset, rsp_valid, seen_ff == 2'd3)

endmodule

bind polyline_corner_detector pcd_checker u_pcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .corner_x  (rsp_chan.corner_x),
   .corner_y  (rsp_chan.corner_y)
);

`default_nettype wire
